// ===== rtl/core/pcs_pkg.sv =====
// shared types, constants and helpers of the polyline convex splitter
package pcs_pkg;

  // fixed field widths
  localparam int IDX_W = 12;
  localparam int TOL_W = 32;
  localparam int CFG_W = 32;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_CLOCKWISE = 1'b0,
    CFG_TURN_TOL  = 1'b1
  } pcs_cfg_e;

  // per item bookkeeping that travels with the arithmetic
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             last;
  } pcs_meta_t;

  // one convex set
  typedef struct packed {
    logic [IDX_W-1:0] first_idx;
    logic [IDX_W-1:0] final_idx;
    logic             last_set;
  } pcs_set_t;

  // status from the decision stage back to the top level
  typedef struct packed {
    logic ready;
    logic pend_valid;
    logic pend_last;
  } pcs_status_t;

  // index increment that stops at the saturation index
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] v,
                                               input logic [IDX_W-1:0] vmax);
    logic [IDX_W-1:0] r;
    if (v >= vmax) begin
      r = vmax;
    end else begin
      r = v + IDX_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/pcs_edge.sv =====
// input stage: previous point, edge forming, point numbering
module pcs_edge import pcs_pkg::*; #(
  parameter int               COORD_BITS = 24,
  parameter logic [IDX_W-1:0] IDX_MAX    = 12'd4095
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic                         accept_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic                         last_point_i,
  input  logic                         clockwise_i,
  output logic                         valid_o,
  output logic signed [COORD_BITS:0]   ex_o,
  output logic signed [COORD_BITS:0]   ey_o,
  output logic signed [COORD_BITS:0]   vx_o,
  output logic signed [COORD_BITS:0]   vy_o,
  output pcs_meta_t                    meta_o
);

  localparam int EW = COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
  logic signed [EW-1:0]         edge_x_q, edge_y_q;
  logic [IDX_W-1:0]             idx_q;
  logic                         valid_q;
  logic signed [EW-1:0]         ex_q, ey_q, vx_q, vy_q;
  pcs_meta_t                    meta_q;

  logic signed [EW-1:0] dx, dy, vx_d, vy_d;

  // new edge, exact, and its turn-sense version
  assign dx   = EW'(point_x_i) - EW'(prev_x_q);
  assign dy   = EW'(point_y_i) - EW'(prev_y_q);
  assign vx_d = clockwise_i ? -dx : dx;
  assign vy_d = clockwise_i ? -dy : dy;

  // running point state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
      edge_x_q <= '0;
      edge_y_q <= '0;
      idx_q    <= '0;
    end else if (accept_i) begin
      prev_x_q <= point_x_i;
      prev_y_q <= point_y_i;
      edge_x_q <= dx;
      edge_y_q <= dy;
      idx_q    <= last_point_i ? '0 : idx_inc(idx_q, IDX_MAX);
    end
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= accept_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      ex_q        <= edge_x_q;
      ey_q        <= edge_y_q;
      vx_q        <= vx_d;
      vy_q        <= vy_d;
      meta_q.idx  <= idx_q;
      meta_q.last <= last_point_i;
    end
  end

  assign valid_o = valid_q;
  assign ex_o    = ex_q;
  assign ey_o    = ey_q;
  assign vx_o    = vx_q;
  assign vy_o    = vy_q;
  assign meta_o  = meta_q;

endmodule

// ===== rtl/core/pcs_cross.sv =====
// product unit: the two terms of the cross product
module pcs_cross #(
  parameter int COORD_BITS = 24
) (
  input  logic signed [COORD_BITS:0]       ex_i,
  input  logic signed [COORD_BITS:0]       ey_i,
  input  logic signed [COORD_BITS:0]       vx_i,
  input  logic signed [COORD_BITS:0]       vy_i,
  output logic signed [2*COORD_BITS+1:0]   p1_o,
  output logic signed [2*COORD_BITS+1:0]   p2_o
);

  localparam int PW = 2 * (COORD_BITS + 1);

  // two independent exact products
  assign p1_o = PW'(ex_i) * PW'(vy_i);
  assign p2_o = PW'(ey_i) * PW'(vx_i);

endmodule

// ===== rtl/core/pcs_split.sv =====
// decision stage: turn test, open set tracking, held set and result register
module pcs_split import pcs_pkg::*; #(
  parameter int               COORD_BITS = 24,
  parameter logic [IDX_W-1:0] IDX_MAX    = 12'd4095
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic signed [2*COORD_BITS+1:0] p1_i,
  input  logic signed [2*COORD_BITS+1:0] p2_i,
  input  pcs_meta_t                      meta_i,
  input  logic [TOL_W-1:0]               turn_tol_i,
  input  logic                           out_stall_i,
  output pcs_status_t                    status_o,
  output logic                           out_valid_o,
  output pcs_set_t                       set_o
);

  localparam int PW = 2 * (COORD_BITS + 1);
  localparam int SW = (((PW + 1) > (TOL_W + 1)) ? (PW + 1) : (TOL_W + 1)) + 1;

  logic [IDX_W-1:0] cur_first_q, cur_first_d;
  logic [IDX_W-1:0] cur_final_q, cur_final_d;
  logic             pend_valid_q, pend_valid_d;
  pcs_set_t         pend_q, pend_d;
  logic             out_valid_q, out_valid_d;
  pcs_set_t         out_q, out_d;

  logic signed [SW-1:0] tol_ext, turn_sum;
  logic                 turn_ok, out_free, fire, has_turn, has_break;
  logic [IDX_W-1:0]     first_a, final_a;
  pcs_set_t             brk_set, last_set;

  // exact turn test: p1 - p2 + tolerance > 0
  assign tol_ext  = $signed({{(SW-TOL_W){1'b0}}, turn_tol_i});
  assign turn_sum = SW'(p1_i) - SW'(p2_i) + tol_ext;
  assign turn_ok  = !turn_sum[SW-1] && (turn_sum != '0);

  assign out_free  = !out_valid_q || !out_stall_i;
  assign fire      = valid_i && out_free;
  assign has_turn  = meta_i.idx >= IDX_W'(2);
  assign has_break = has_turn && !turn_ok;

  // open set after the turn test
  always_comb begin
    first_a = cur_first_q;
    final_a = cur_final_q;
    if (has_turn) begin
      if (turn_ok) begin
        final_a = meta_i.idx;
      end else begin
        first_a = cur_final_q;
        final_a = idx_inc(cur_final_q, IDX_MAX);
      end
    end
  end

  // sets this item can close
  assign brk_set.first_idx  = cur_first_q;
  assign brk_set.final_idx  = cur_final_q;
  assign brk_set.last_set   = 1'b0;
  assign last_set.first_idx = first_a;
  assign last_set.final_idx = (meta_i.idx == '0) ? '0 : final_a;
  assign last_set.last_set  = 1'b1;

  // pick the oldest set for output, keep the next one
  always_comb begin
    cur_first_d  = cur_first_q;
    cur_final_d  = cur_final_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    if (out_free) begin
      out_valid_d = 1'b0;
    end
    if (fire) begin
      if (meta_i.last) begin
        cur_first_d = '0;
        cur_final_d = IDX_W'(1);
      end else begin
        cur_first_d = first_a;
        cur_final_d = final_a;
      end
      pend_valid_d = 1'b0;
      priority if (pend_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = pend_q;
        pend_valid_d = has_break || meta_i.last;
        pend_d       = has_break ? brk_set : last_set;
      end else if (has_break) begin
        out_valid_d  = 1'b1;
        out_d        = brk_set;
        pend_valid_d = meta_i.last;
        pend_d       = last_set;
      end else if (meta_i.last) begin
        out_valid_d  = 1'b1;
        out_d        = last_set;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_first_q  <= '0;
      cur_final_q  <= IDX_W'(1);
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      cur_first_q  <= cur_first_d;
      cur_final_q  <= cur_final_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // held set and result payload
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign status_o.ready      = out_free;
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.pend_last  = pend_q.last_set;
  assign out_valid_o         = out_valid_q;
  assign set_o               = out_q;

endmodule

// ===== rtl/core/polyline_convex_splitter.sv =====
// polyline convex splitter: from accepting a point to its set on the output, the point
// passes the input register, then cross product and turn test into the result register
// throughput one point per cycle; a stalled result holds the input register
// a set held back when two close on the last point leaves with the next point
// reset: asynchronous active low, clears pipeline, open set 0..1, clockwise 0,
// turn tolerance 43
module polyline_convex_splitter import pcs_pkg::*; #(
  parameter int MAX_POINTS = 4096,
  parameter int COORD_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [0:0]                   cfg_idx_i,
  input  logic [CFG_W-1:0]             cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic                         last_point_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [IDX_W-1:0]             set_first_o,
  output logic [IDX_W-1:0]             set_final_o,
  output logic                         last_set_o
);

  localparam int               IdxMaxInt = ((MAX_POINTS - 1) < 4095) ? (MAX_POINTS - 1) : 4095;
  localparam logic [IDX_W-1:0] IdxMax    = IDX_W'(IdxMaxInt);
  localparam int               EW        = COORD_BITS + 1;
  localparam int               PW        = 2 * EW;

  logic             clockwise_q;
  logic [TOL_W-1:0] turn_tol_q;

  logic                 s1_valid, s1_load, accept;
  logic signed [EW-1:0] ex, ey, vx, vy;
  pcs_meta_t            s1_meta;
  logic signed [PW-1:0] p1, p2;
  pcs_status_t          status;
  pcs_set_t             set_out;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clockwise_q <= 1'b0;
      turn_tol_q  <= TOL_W'(43);
    end else if (cfg_we_i) begin
      unique case (pcs_cfg_e'(cfg_idx_i))
        CFG_CLOCKWISE: clockwise_q <= cfg_data_i[0];
        CFG_TURN_TOL:  turn_tol_q  <= cfg_data_i[TOL_W-1:0];
        default:       clockwise_q <= clockwise_q;
      endcase
    end
  end

  // input register loads when empty or when its item moves on
  assign s1_load    = !s1_valid || status.ready;
  assign accept     = in_valid_i && s1_load;
  assign in_stall_o = !s1_load;

  pcs_edge #(
    .COORD_BITS (COORD_BITS),
    .IDX_MAX    (IdxMax)
  ) u_edge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (s1_load),
    .accept_i     (accept),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .last_point_i (last_point_i),
    .clockwise_i  (clockwise_q),
    .valid_o      (s1_valid),
    .ex_o         (ex),
    .ey_o         (ey),
    .vx_o         (vx),
    .vy_o         (vy),
    .meta_o       (s1_meta)
  );

  pcs_cross #(
    .COORD_BITS (COORD_BITS)
  ) u_cross (
    .ex_i (ex),
    .ey_i (ey),
    .vx_i (vx),
    .vy_i (vy),
    .p1_o (p1),
    .p2_o (p2)
  );

  pcs_split #(
    .COORD_BITS (COORD_BITS),
    .IDX_MAX    (IdxMax)
  ) u_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid),
    .p1_i        (p1),
    .p2_i        (p2),
    .meta_i      (s1_meta),
    .turn_tol_i  (turn_tol_q),
    .out_stall_i (out_stall_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .set_o       (set_out)
  );

  assign set_first_o = set_out.first_idx;
  assign set_final_o = set_out.final_idx;
  assign last_set_o  = set_out.last_set;

  // back pressure on the input comes only from a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // a set never ends before it starts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (set_first_o <= set_final_o))
    else $error("set ends before its first point");

  // a held set appears only with an inner break set and is always the final set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(status.pend_valid) |-> (out_valid_o && !last_set_o && status.pend_last))
    else $error("held set without a break on the last point");

endmodule
